// ----- rtl/lbc32_pkg.sv -----
// Package for the 32-bit lightweight block cipher encryptor.
// Widths, register indexes and the round functions used by the core and the top level.
// No dependencies.
`default_nettype none

package lbc32_pkg;

  localparam int unsigned BLOCK_W            = 32;
  localparam int unsigned KEY_W              = 64;
  localparam int unsigned RCNT_W             = 6;
  localparam int unsigned RNUM_W             = 8;
  localparam int unsigned CFG_IDX_W          = 2;
  localparam int unsigned CFG_DATA_W         = 32;
  localparam int unsigned DEFAULT_MAX_ROUNDS = 32;

  localparam logic [RCNT_W-1:0] RCNT_RESET = 6'd32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 2'd2;

  // key state permutation masks
  localparam logic [KEY_W-1:0] KS_MASK_A = 64'h0000_000f_ffff_ff00;
  localparam logic [KEY_W-1:0] KS_MASK_B = 64'h0000_fff0_0000_0000;
  localparam logic [KEY_W-1:0] KS_MASK_C = 64'hffff_0000_0000_0000;
  localparam logic [KEY_W-1:0] KS_MASK_D = 64'h0000_0000_0000_000f;
  localparam logic [KEY_W-1:0] KS_MASK_E = 64'h0000_0000_0000_00f0;

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int unsigned n);
    logic [15:0] dbl;
    dbl = {x, x} << n;
    return dbl[15:8];
  endfunction

  // f(x) = (rol1 & rol7) ^ rol2
  function automatic logic [7:0] mixf(input logic [7:0] x);
    return (rotl8(x, 1) & rotl8(x, 7)) ^ rotl8(x, 2);
  endfunction

  // NX mix; position p is bit 7-p
  function automatic logic [7:0] nx_mix(input logic [7:0] b);
    logic [7:0] pin;
    logic [7:0] t;
    logic [7:0] res;
    for (int p = 0; p < 8; p++) begin
      pin[p] = b[7-p];
    end
    t[0] = pin[0] ^ pin[6];
    t[2] = pin[2] ^ t[0];
    t[4] = pin[4] ^ t[2];
    t[6] = pin[6] ^ t[4];
    t[1] = pin[1] ^ pin[7];
    t[3] = pin[3] ^ t[1];
    t[5] = pin[5] ^ t[3];
    t[7] = pin[7] ^ t[5];
    for (int p = 0; p < 8; p++) begin
      res[7-p] = t[p] & pin[p];
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] key_advance(input logic [KEY_W-1:0] ks_in,
                                                   input logic [RNUM_W-1:0] rnum);
    logic [KEY_W-1:0] ks;
    ks = ks_in ^ {rnum, 56'd0};
    ks = {ks[KEY_W-1:8], nx_mix(ks[7:0])};
    return ((ks & KS_MASK_A) << 8)
         | ((ks & KS_MASK_B) << 12)
         | ((ks & KS_MASK_C) >> 48)
         | ((ks & KS_MASK_D) << 44)
         | ((ks & KS_MASK_E) << 56);
  endfunction

  // one data round: two byte branches then the byte rotation
  function automatic logic [BLOCK_W-1:0] data_round(input logic [BLOCK_W-1:0] blk,
                                                    input logic [KEY_W-1:0] ks);
    logic [7:0] l0, l1, r0, r1;
    logic [7:0] kl0, kl1, kr0, kr1;
    l0  = blk[31:24];
    l1  = blk[23:16];
    r0  = blk[15:8];
    r1  = blk[7:0];
    kl0 = {ks[63:60], ks[55:52]};
    kr0 = {ks[59:56], ks[51:48]};
    kl1 = {ks[47:44], ks[39:36]};
    kr1 = {ks[43:40], ks[35:32]};
    l1  = l1 ^ mixf(l0) ^ kl0;
    l0  = l0 ^ mixf(l1) ^ kl1;
    r1  = r1 ^ mixf(r0) ^ kr0;
    r0  = r0 ^ mixf(r1) ^ kr1;
    // l0 <- r1, l1 <- l0, r0 <- l1, r1 <- r0
    return {r1, l0, l1, r0};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lbc32_rounds.sv -----
// Unrolled round network of the 32-bit lightweight block cipher.
// Pure combinational; uses lbc32_pkg.
`default_nettype none

module lbc32_rounds #(
  parameter int unsigned MAX_ROUNDS = lbc32_pkg::DEFAULT_MAX_ROUNDS
) (
  input  wire logic [lbc32_pkg::BLOCK_W-1:0] block_i,
  input  wire logic [lbc32_pkg::KEY_W-1:0]   key_i,
  input  wire logic [lbc32_pkg::RCNT_W-1:0]  rounds_i,
  output logic      [lbc32_pkg::BLOCK_W-1:0] block_o
);
  import lbc32_pkg::*;

  logic [KEY_W-1:0]   ks  [MAX_ROUNDS+1];
  logic [BLOCK_W-1:0] blk [MAX_ROUNDS+1];

  assign ks[0]  = key_i;
  assign blk[0] = block_i;

  // round i runs when i < rounds_i; i never reaches MAX_ROUNDS, so that saturates
  for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_round
    logic en;
    assign en       = {{(RNUM_W-RCNT_W){1'b0}}, rounds_i} > RNUM_W'(i);
    assign ks[i+1]  = key_advance(ks[i], RNUM_W'(i + 1));
    assign blk[i+1] = en ? data_round(blk[i], ks[i+1]) : blk[i];
  end

  assign block_o = blk[MAX_ROUNDS];

endmodule

`default_nettype wire

// ----- rtl/lightweight_block_cipher_32_encrypt.sv -----
// Top level of the 32-bit lightweight block cipher encryptor.
// Holds configuration, input and result registers; uses lbc32_pkg and lbc32_rounds.
//
//   channel   dir  handshake                   payload
//   s_axis    in   s_axis_tvalid/tready        tdata[31:0] plaintext
//   m_axis    out  m_axis_tvalid/tready        tdata[31:0] ciphertext
//   cfg       in   cfg_valid/cfg_ready         cfg_index (0 key_high, 1 key_low,
//                                              2 round_count), cfg_data
//
// One word per cycle sustained while m_axis_tready is high; each accepted word
// passes the input register, the unrolled rounds and the result register.
// Cycles per word do not depend on round_count; counts above MAX_ROUNDS
// saturate in the unrolled network.
// Reset clears valids and loads key 0 and round_count 32.
// A stall on m_axis holds the result; the input register keeps filling
// until both stages hold a word.
`default_nettype none

module lightweight_block_cipher_32_encrypt #(
  parameter int unsigned MAX_ROUNDS = lbc32_pkg::DEFAULT_MAX_ROUNDS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // slave side
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [lbc32_pkg::BLOCK_W-1:0]       s_axis_tdata,   // [31:0] plaintext
  // master side
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic      [lbc32_pkg::BLOCK_W-1:0]       m_axis_tdata,   // [31:0] ciphertext
  // configuration write
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [lbc32_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [lbc32_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import lbc32_pkg::*;

  logic [31:0]        key_high_q;
  logic [31:0]        key_low_q;
  logic [RCNT_W-1:0]  rcnt_q;

  logic               in_vld_q;
  logic [BLOCK_W-1:0] in_q;
  logic               out_vld_q;
  logic [BLOCK_W-1:0] out_q;
  logic [BLOCK_W-1:0] ct;

  logic               out_ready;
  logic               in_ready;

  // config writes always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      rcnt_q     <= RCNT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_KEY_HIGH:    key_high_q <= cfg_data_i;
        REG_KEY_LOW:     key_low_q  <= cfg_data_i;
        REG_ROUND_COUNT: rcnt_q     <= cfg_data_i[RCNT_W-1:0];
        default:         ;  // unused index, write dropped
      endcase
    end
  end

  // two-stage pipe; each stage loads when empty or when its word moves on
  assign out_ready     = !out_vld_q || m_axis_tready;
  assign in_ready      = !in_vld_q || out_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_q <= s_axis_tdata;
    end
    if (out_ready && in_vld_q) begin
      out_q <= ct;
    end
  end

  lbc32_rounds #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_rounds (
    .block_i (in_q),
    .key_i   ({key_high_q, key_low_q}),
    .rounds_i(rcnt_q),
    .block_o (ct)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// ----- bench/lightweight_block_cipher_32_encrypt_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for lightweight_block_cipher_32_encrypt: plaintext words in,
// ciphertext words predicted by a scoreboard class and compared word by word.
// Depends on lbc32_pkg (register indexes, widths) and the block's RTL only.

// Expected-ciphertext store with its own copy of the key and round registers.
class lbc32_ciphertext_board;
  logic [31:0] key_hi;
  logic [31:0] key_lo;
  logic [5:0]  rounds;
  logic [31:0] ciphertext_q[$];
  int unsigned blocks_in;
  int unsigned blocks_out;
  int unsigned errors;

  function new();
    key_hi     = '0;
    key_lo     = '0;
    rounds     = lbc32_pkg::RCNT_RESET;
    blocks_in  = 0;
    blocks_out = 0;
    errors     = 0;
  endfunction

  function void write_reg(logic [lbc32_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      lbc32_pkg::REG_KEY_HIGH:    key_hi = val;
      lbc32_pkg::REG_KEY_LOW:     key_lo = val;
      lbc32_pkg::REG_ROUND_COUNT: rounds = val[5:0];
      default: ;  // unmapped index: dropped
    endcase
  endfunction

  function logic [7:0] byte_rol(logic [7:0] x, int unsigned n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function logic [7:0] byte_f(logic [7:0] x);
    return (byte_rol(x, 1) & byte_rol(x, 7)) ^ byte_rol(x, 2);
  endfunction

  // nonlinear mix of the key's low byte: two XOR chains, one over bits 7,5,3,1
  // and one over bits 6,4,2,0, each ANDed back with the input bit
  function logic [7:0] key_nx(logic [7:0] b);
    logic [7:0] c;
    c[7] = b[7] ^ b[1];
    c[5] = b[5] ^ c[7];
    c[3] = b[3] ^ c[5];
    c[1] = b[1] ^ c[3];
    c[6] = b[6] ^ b[0];
    c[4] = b[4] ^ c[6];
    c[2] = b[2] ^ c[4];
    c[0] = b[0] ^ c[2];
    return c & b;
  endfunction

  function logic [63:0] key_step(logic [63:0] ks, int unsigned rnd);
    logic [63:0] r;
    r      = ks ^ (64'(rnd + 1) << 56);
    r[7:0] = key_nx(r[7:0]);
    // nibble-group permutation
    return {r[7:4], r[47:36], r[3:0], r[35:8], r[63:48]};
  endfunction

  function logic [31:0] encrypt_block(logic [31:0] pt);
    logic [63:0] ks;
    logic [7:0]  l0, l1, r0, r1, t;
    logic [7:0]  kl0, kl1, kr0, kr1;
    int unsigned n;
    ks = {key_hi, key_lo};
    {l0, l1, r0, r1} = pt;
    // counts past the unrolled depth saturate; zero rounds passes the word through
    n = (rounds > lbc32_pkg::DEFAULT_MAX_ROUNDS) ? lbc32_pkg::DEFAULT_MAX_ROUNDS : rounds;
    for (int unsigned i = 0; i < n; i++) begin
      ks  = key_step(ks, i);
      kl0 = {ks[63:60], ks[55:52]};
      kr0 = {ks[59:56], ks[51:48]};
      kl1 = {ks[47:44], ks[39:36]};
      kr1 = {ks[43:40], ks[35:32]};
      l1  = l1 ^ byte_f(l0) ^ kl0;
      l0  = l0 ^ byte_f(l1) ^ kl1;
      r1  = r1 ^ byte_f(r0) ^ kr0;
      r0  = r0 ^ byte_f(r1) ^ kr1;
      t   = l0;
      l0  = r1;
      r1  = r0;
      r0  = l1;
      l1  = t;
    end
    return {l0, l1, r0, r1};
  endfunction

  function void note_plaintext(logic [31:0] pt);
    ciphertext_q.push_back(encrypt_block(pt));
    blocks_in++;
  endfunction

  function void check_ciphertext(logic [31:0] ct);
    logic [31:0] exp_ct;
    blocks_out++;
    if (ciphertext_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: unexpected ciphertext word %08h", ct);
      return;
    end
    exp_ct = ciphertext_q.pop_front();
    if (ct !== exp_ct) begin
      errors++;
      if (errors <= 10) $display("ERROR: ciphertext expected %08h got %08h", exp_ct, ct);
    end
  endfunction
endclass

module lightweight_block_cipher_32_encrypt_tb;

  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_BLOCKS = 95;
  localparam int unsigned LONG_HOLD    = 80;
  // round count per random phase; -1 picks one at random (0..63)
  localparam int PHASE_RC[PHASES] = '{32, 1, 63, 33, 32, 2, 0, -1, 31, -1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] plaintext
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] ciphertext
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [lbc32_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [lbc32_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // idling knobs, percent per cycle; set by the main sequence at phase changes
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  // long receiver hold-off, counted down by the receiver process
  int unsigned hold_left = 0;
  int unsigned settings_run = 0;

  lbc32_ciphertext_board board = new();

  lightweight_block_cipher_32_encrypt dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Offer one plaintext word, with random idle cycles ahead of it. Returns at the
  // edge where the word was taken; tvalid stays high so back-to-back words flow.
  task automatic send_block(input logic [31:0] pt);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pt;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    board.note_plaintext(pt);
  endtask

  // One register write; cfg_valid_i is left high for a following write.
  task automatic write_reg(input logic [lbc32_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    board.write_reg(idx, val);
  endtask

  // Full register load; also pokes the unmapped index, which must be ignored.
  // Upper data bits of the round count word are random and must not matter.
  task automatic load_regs(input logic [31:0] kh, input logic [31:0] kl,
                           input logic [5:0] rc);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(2'd3, junk);
    write_reg(lbc32_pkg::REG_KEY_HIGH, kh);
    write_reg(lbc32_pkg::REG_KEY_LOW, kl);
    write_reg(lbc32_pkg::REG_ROUND_COUNT, {junk[31:6], rc});
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  // Drop tvalid and wait until every expected word is back from the two-stage pipe.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.ciphertext_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_plaintext();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0001 << $urandom_range(1);
      default: return $urandom();
    endcase
  endfunction

  // Receiver: checks each accepted word, then picks tready for the next edge.
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) board.check_ciphertext(m_axis_tdata);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Main sequence: directed corners first, then random phases.
  initial begin
    logic [31:0] kh, kl;
    logic [5:0]  rc;
    logic [31:0] corner_pts[6];
    corner_pts = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
                   32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: zero key, full 32 rounds
    foreach (corner_pts[k]) send_block(corner_pts[k]);
    drain();

    // all-ones key, zero rounds: ciphertext must equal plaintext
    load_regs('1, '1, 6'd0);
    send_block(32'h0000_0000);
    send_block(32'hffff_ffff);
    send_block(32'h1234_5678);
    drain();

    // single round
    load_regs(32'h0123_4567, 32'h89ab_cdef, 6'd1);
    send_block(32'h0000_0000);
    send_block(32'hffff_ffff);
    send_block(32'hdead_beef);
    drain();

    // counts above the unrolled depth saturate
    load_regs(32'hffff_ffff, 32'h0000_0000, 6'd63);
    send_block(32'h0000_0000);
    send_block(32'hffff_ffff);
    send_block(32'h0f0f_f0f0);
    drain();
    load_regs(32'h0000_0000, 32'hffff_ffff, 6'd33);
    send_block(32'hffff_ffff);
    send_block(32'h7f7f_8080);
    drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      kh = (p == 0) ? '0 : (p == 1) ? '1 : $urandom();
      kl = (p == 0) ? '0 : (p == 1) ? '1 : $urandom();
      rc = (PHASE_RC[p] < 0) ? 6'($urandom_range(63)) : 6'(PHASE_RC[p]);
      load_regs(kh, kl, rc);
      case (p % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 51;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 51;
        end
        default: begin
          gap_pct   = 18;
          stall_pct = 18;
        end
      endcase
      // back-pressure: receiver holds off while words keep coming, so both
      // stages fill and s_axis_tready must drop
      if (p == 4 || p == 8) hold_left = LONG_HOLD;
      repeat (PHASE_BLOCKS) send_block(random_plaintext());
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("Run covered %0d plaintext words and %0d ciphertext words over %0d register loads,",
             board.blocks_in, board.blocks_out, settings_run);
    $display("round counts 0, 1, 2, 31, 32, 33, 63 and random, with stalls and back-pressure.");
    if (board.errors == 0 && board.ciphertext_q.size() == 0) begin
      $display("lightweight_block_cipher_32_encrypt test passed");
    end else begin
      $display("lightweight_block_cipher_32_encrypt test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("lightweight_block_cipher_32_encrypt test failed");
    $finish;
  end

endmodule
